/* rtl/c_subset_lexical_scanner_unit_macros.svh */
// assertion helpers used by the checker file
`ifndef C_SUBSET_LEXICAL_SCANNER_UNIT_MACROS_SVH
`define C_SUBSET_LEXICAL_SCANNER_UNIT_MACROS_SVH

// same-cycle implication
`define SCL_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SCL_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/scl_pkg.sv */
`timescale 1ns / 1ps

package scl_pkg;

    typedef enum logic [3:0] {
        M_IDLE  = 4'd0,
        M_NUM   = 4'd1,
        M_IDENT = 4'd2,
        M_QOPEN = 4'd3,
        M_QGOT  = 4'd4,
        M_SLASH = 4'd5,
        M_LINEC = 4'd6,
        M_BLOCK = 4'd7,
        M_BSTAR = 4'd8,
        M_OP    = 4'd9
    } mode_t;

    typedef enum logic [5:0] {
        TK_END       = 6'd0,
        TK_ERROR     = 6'd1,
        TK_IDENT     = 6'd2,
        TK_NUM       = 6'd3,
        TK_CHAR      = 6'd4,
        TK_KW_FLOAT  = 6'd5,
        TK_KW_DOUBLE = 6'd6,
        TK_KW_INT    = 6'd7,
        TK_KW_MAIN   = 6'd8,
        TK_KW_DO     = 6'd9,
        TK_KW_WHILE  = 6'd10,
        TK_KW_RETURN = 6'd11,
        TK_LT        = 6'd12,
        TK_LE        = 6'd13,
        TK_GT        = 6'd14,
        TK_GE        = 6'd15,
        TK_NE        = 6'd16,
        TK_PLUS      = 6'd17,
        TK_PLUS_EQ   = 6'd18,
        TK_INC       = 6'd19,
        TK_MINUS     = 6'd20,
        TK_MINUS_EQ  = 6'd21,
        TK_DEC       = 6'd22,
        TK_STAR      = 6'd23,
        TK_STAR_EQ   = 6'd24,
        TK_SLASH     = 6'd25,
        TK_SLASH_EQ  = 6'd26,
        TK_PCT       = 6'd27,
        TK_PCT_EQ    = 6'd28,
        TK_ASSIGN    = 6'd29,
        TK_EQ        = 6'd30,
        TK_LPAREN    = 6'd31,
        TK_RPAREN    = 6'd32,
        TK_LBRACE    = 6'd33,
        TK_RBRACE    = 6'd34,
        TK_LBRACK    = 6'd35,
        TK_RBRACK    = 6'd36,
        TK_SEMI      = 6'd37,
        TK_COMMA     = 6'd38
    } token_kind_t;

    typedef enum logic [2:0] {
        ERR_NONE         = 3'd0,
        ERR_UNKNOWN      = 3'd1,
        ERR_LONE_BANG    = 3'd2,
        ERR_INT_LONG     = 3'd3,
        ERR_IDENT_LONG   = 3'd4,
        ERR_CHAR_OPEN    = 3'd5,
        ERR_COMMENT_OPEN = 3'd6
    } err_code_t;

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam int         KW_NUM = 7;

    // keyword text packed first character in the low byte
    localparam logic [55:0] KW_TEXT [KW_NUM] = '{
        56'h0000_0074_616f_6c66,   // float
        56'h0000_656c_6275_6f64,   // double
        56'h0000_0000_0074_6e69,   // int
        56'h0000_0000_6e69_616d,   // main
        56'h0000_0000_0000_6f64,   // do
        56'h0000_0065_6c69_6877,   // while
        56'h0000_6e72_7574_6572    // return
    };
    localparam logic [2:0] KW_LEN [KW_NUM] = '{3'd5, 3'd6, 3'd3, 3'd4, 3'd2, 3'd5, 3'd6};

    typedef struct packed {
        mode_t       mode;
        logic [55:0] lex;
        logic [2:0]  cnt;
        logic        ovf;
    } scan_st_t;

    typedef struct packed {
        logic        valid;
        token_kind_t kind;
        logic [55:0] lex;
        logic [2:0]  len;
        err_code_t   err;
    } tok_t;

    typedef struct packed {
        scan_st_t st;
        tok_t     tok;
        logic     rescan;
        logic     line_inc;
    } step_t;

    typedef struct packed {
        token_kind_t kind;
        logic [55:0] lex;
        logic [2:0]  len;
        logic [15:0] line;
        err_code_t   err;
        logic        last;
    } res_t;

endpackage

/* rtl/c_subset_lexical_scanner_unit.sv */
`timescale 1ns / 1ps

// Lexical scanner for a small C subset.
// Input channel s_*: one source character per word on s_ch; a zero character
// ends the text and yields an end token, after which more text may follow.
// Output channel m_*: one token per word with kind, up to seven lexeme bytes
// (first in the low byte), length, line number and error code. m_last_of_run
// marks the final token caused by one input character.
// Most tokens are closed by the character after them, so one character can give zero,
// one or two tokens. Scanning is done in the accept cycle by the state
// registers and their next-state logic; tokens go into a three-word result
// queue whose head drives the m_ ports, so a token is registered in the queue
// when the character that caused it is accepted.
// Throughput is one character per cycle while m_ready stays high and each
// character yields at most one token; the single output word per cycle sets
// that figure, and a character yielding two tokens holds s_ready low for one cycle.
// When the receiver stalls, the queue fills and s_ready drops once two words
// are waiting; nothing is lost. Reset (synchronous, aresetn low) empties the
// queue, returns the scanner to idle and sets the line count to one.
module c_subset_lexical_scanner_unit #(
    parameter int LEXEME_MAX = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_ch,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [5:0]  m_token_kind,
    output logic [55:0] m_lexeme,
    output logic [2:0]  m_lexeme_length,
    output logic [15:0] m_line_number,
    output logic [2:0]  m_error_code,
    output logic        m_last_of_run
);
    import scl_pkg::*;

    localparam logic [2:0] LIM = 3'(LEXEME_MAX - 1);
    localparam scan_st_t ST_IDLE = '{mode: M_IDLE, lex: '0, cnt: '0, ovf: 1'b0};
    localparam tok_t TOK_NONE = '{valid: 1'b0, kind: TK_END, lex: '0, len: '0,
                                  err: ERR_NONE};

    function automatic logic is_digit(logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
    endfunction

    function automatic tok_t mk_tok(token_kind_t k, logic [55:0] lex, logic [2:0] len,
                                    err_code_t e);
        tok_t t;
        t.valid = 1'b1;
        t.kind  = k;
        t.lex   = lex;
        t.len   = len;
        t.err   = e;
        return t;
    endfunction

    function automatic scan_st_t start_st(mode_t m, logic [7:0] c);
        scan_st_t s;
        s.mode = m;
        s.lex  = {48'd0, c};
        s.cnt  = 3'd1;
        s.ovf  = 1'b0;
        return s;
    endfunction

    function automatic scan_st_t append(scan_st_t s, logic [7:0] c);
        scan_st_t r;
        r = s;
        if (s.cnt < LIM) begin
            for (int i = 0; i < 7; i++) begin
                if (s.cnt == 3'(i)) r.lex[8*i +: 8] = c;
            end
            r.cnt = s.cnt + 3'd1;
        end else begin
            r.ovf = 1'b1;
        end
        return r;
    endfunction

    // first characters of operators that may take a second one
    function automatic token_kind_t op_single(logic [7:0] f);
        token_kind_t k;
        unique case (f)
            "<":     k = TK_LT;
            ">":     k = TK_GT;
            "!":     k = TK_NE;
            "+":     k = TK_PLUS;
            "-":     k = TK_MINUS;
            "*":     k = TK_STAR;
            "%":     k = TK_PCT;
            "=":     k = TK_ASSIGN;
            default: k = TK_END;
        endcase
        return k;
    endfunction

    function automatic token_kind_t op_double(logic [7:0] f, logic [7:0] c);
        token_kind_t k;
        k = TK_END;
        if (c == "=") begin
            unique case (f)
                "<":     k = TK_LE;
                ">":     k = TK_GE;
                "!":     k = TK_NE;
                "+":     k = TK_PLUS_EQ;
                "-":     k = TK_MINUS_EQ;
                "*":     k = TK_STAR_EQ;
                "%":     k = TK_PCT_EQ;
                "=":     k = TK_EQ;
                default: k = TK_END;
            endcase
        end else if (f == "+" && c == "+") begin
            k = TK_INC;
        end else if (f == "-" && c == "-") begin
            k = TK_DEC;
        end
        return k;
    endfunction

    function automatic token_kind_t punct_kind(logic [7:0] c);
        token_kind_t k;
        unique case (c)
            "(":     k = TK_LPAREN;
            ")":     k = TK_RPAREN;
            "{":     k = TK_LBRACE;
            "}":     k = TK_RBRACE;
            "[":     k = TK_LBRACK;
            "]":     k = TK_RBRACK;
            ";":     k = TK_SEMI;
            ",":     k = TK_COMMA;
            default: k = TK_END;
        endcase
        return k;
    endfunction

    // seven keyword comparators side by side
    function automatic token_kind_t ident_kind(scan_st_t s);
        token_kind_t k;
        k = TK_IDENT;
        for (int i = KW_NUM - 1; i >= 0; i--) begin
            if (s.cnt == KW_LEN[i] && s.lex == KW_TEXT[i]) begin
                k = token_kind_t'(6'(int'(TK_KW_FLOAT) + i));
            end
        end
        return k;
    endfunction

    // character seen between tokens
    function automatic step_t idle_step(logic [7:0] c);
        step_t   r;
        token_kind_t pk;
        r.st       = ST_IDLE;
        r.tok      = TOK_NONE;
        r.rescan   = 1'b0;
        r.line_inc = 1'b0;
        pk = punct_kind(c);
        if (c == " " || c == "\t") begin
            r.st = ST_IDLE;
        end else if (c == "\n") begin
            r.line_inc = 1'b1;
        end else if (c == CH_NUL) begin
            r.tok = mk_tok(TK_END, '0, '0, ERR_NONE);
        end else if (is_digit(c)) begin
            r.st = start_st(M_NUM, c);
        end else if (is_alpha(c)) begin
            r.st = start_st(M_IDENT, c);
        end else if (c == "'") begin
            r.st.mode = M_QOPEN;
        end else if (c == "/") begin
            r.st = start_st(M_SLASH, c);
        end else if (op_single(c) != TK_END) begin
            r.st = start_st(M_OP, c);
        end else if (pk != TK_END) begin
            r.tok = mk_tok(pk, {48'd0, c}, 3'd1, ERR_NONE);
        end else begin
            r.tok = mk_tok(TK_ERROR, {48'd0, c}, 3'd1, ERR_UNKNOWN);
        end
        return r;
    endfunction

    // character fed to a token or comment in progress
    function automatic step_t busy_step(scan_st_t s, logic [7:0] c);
        step_t       r;
        scan_st_t    a;
        token_kind_t k;
        r.st       = ST_IDLE;
        r.tok      = TOK_NONE;
        r.rescan   = 1'b0;
        r.line_inc = 1'b0;
        a = append(s, c);
        k = op_double(s.lex[7:0], c);
        unique case (s.mode)
            M_NUM: begin
                if (is_digit(c)) begin
                    r.st = a;
                end else begin
                    r.tok = s.ovf ? mk_tok(TK_ERROR, s.lex, s.cnt, ERR_INT_LONG)
                                  : mk_tok(TK_NUM, s.lex, s.cnt, ERR_NONE);
                    r.rescan = 1'b1;
                end
            end
            M_IDENT: begin
                if (is_digit(c) || is_alpha(c)) begin
                    r.st = a;
                end else begin
                    r.tok = s.ovf ? mk_tok(TK_ERROR, s.lex, s.cnt, ERR_IDENT_LONG)
                                  : mk_tok(ident_kind(s), s.lex, s.cnt, ERR_NONE);
                    r.rescan = 1'b1;
                end
            end
            M_QOPEN: begin
                if (c != CH_NUL && c != "\n") begin
                    r.st = start_st(M_QGOT, c);
                end else begin
                    r.tok    = mk_tok(TK_ERROR, '0, '0, ERR_CHAR_OPEN);
                    r.rescan = 1'b1;
                end
            end
            M_QGOT: begin
                if (c == "'") begin
                    r.tok = mk_tok(TK_CHAR, s.lex, s.cnt, ERR_NONE);
                end else begin
                    r.tok    = mk_tok(TK_ERROR, s.lex, s.cnt, ERR_CHAR_OPEN);
                    r.rescan = 1'b1;
                end
            end
            M_SLASH: begin
                if (c == "/") begin
                    r.st.mode = M_LINEC;
                end else if (c == "*") begin
                    r.st.mode = M_BLOCK;
                end else if (c == "=") begin
                    // append is bounded, so a short limit keeps only the slash
                    r.tok = mk_tok(TK_SLASH_EQ, a.lex, a.cnt, ERR_NONE);
                end else begin
                    r.tok    = mk_tok(TK_SLASH, s.lex, s.cnt, ERR_NONE);
                    r.rescan = 1'b1;
                end
            end
            M_LINEC: begin
                if (c == "\n" || c == CH_NUL) begin
                    r.rescan = 1'b1;
                end else begin
                    r.st.mode = M_LINEC;
                end
            end
            M_BLOCK, M_BSTAR: begin
                if (c == CH_NUL) begin
                    r.tok = mk_tok(TK_END, '0, '0, ERR_COMMENT_OPEN);
                end else if (s.mode == M_BSTAR && c == "/") begin
                    r.st = ST_IDLE;
                end else begin
                    r.line_inc = (c == "\n");
                    r.st.mode  = (c == "*") ? M_BSTAR : M_BLOCK;
                end
            end
            M_OP: begin
                if (k != TK_END) begin
                    r.tok = mk_tok(k, {s.lex[55:16], c, s.lex[7:0]}, 3'd2, ERR_NONE);
                end else begin
                    r.tok = (s.lex[7:0] == "!")
                          ? mk_tok(TK_ERROR, s.lex, s.cnt, ERR_LONE_BANG)
                          : mk_tok(op_single(s.lex[7:0]), s.lex, s.cnt, ERR_NONE);
                    r.rescan = 1'b1;
                end
            end
            default: begin
                r.rescan = 1'b1;
            end
        endcase
        return r;
    endfunction

    mode_t       mode_reg, mode_next;
    logic [55:0] lex_reg, lex_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic        ovf_reg, ovf_next;
    logic [15:0] line_reg, line_next;

    res_t        q_reg [3];
    res_t        q_next [3];
    logic [1:0]  qcnt_reg, qcnt_next;

    scan_st_t    st_cur, st_sel;
    step_t       b_step, i_step;
    logic        use_idle, line_inc;
    tok_t        tok_a, tok_b;
    res_t        res_first, res_second;
    logic [1:0]  n_res;
    logic        push, pop;
    logic [1:0]  base;

    assign st_cur = '{mode: mode_reg, lex: lex_reg, cnt: cnt_reg, ovf: ovf_reg};

    always_comb begin
        b_step   = busy_step(st_cur, s_ch);
        i_step   = idle_step(s_ch);
        use_idle = (mode_reg == M_IDLE) || b_step.rescan;
    end

    // next state of the scanner
    always_comb begin
        st_sel    = use_idle ? i_step.st : b_step.st;
        line_inc  = use_idle ? i_step.line_inc : b_step.line_inc;
        mode_next = st_sel.mode;
        lex_next  = st_sel.lex;
        cnt_next  = st_sel.cnt;
        ovf_next  = st_sel.ovf;
        line_next = (line_inc && line_reg != 16'hFFFF) ? line_reg + 16'd1 : line_reg;
    end

    // tokens of this character, packed to the front
    always_comb begin
        if (mode_reg == M_IDLE) begin
            tok_a = i_step.tok;
            tok_b = TOK_NONE;
        end else begin
            tok_a = b_step.tok;
            tok_b = b_step.rescan ? i_step.tok : TOK_NONE;
        end
        n_res = {1'b0, tok_a.valid} + {1'b0, tok_b.valid};
        res_first = '{kind: tok_a.kind, lex: tok_a.lex, len: tok_a.len, line: line_reg,
                      err: tok_a.err, last: !tok_b.valid};
        if (!tok_a.valid) begin
            res_first = '{kind: tok_b.kind, lex: tok_b.lex, len: tok_b.len,
                          line: line_reg, err: tok_b.err, last: 1'b1};
        end
        res_second = '{kind: tok_b.kind, lex: tok_b.lex, len: tok_b.len, line: line_reg,
                       err: tok_b.err, last: 1'b1};
    end

    assign s_ready = !qcnt_reg[1];
    assign m_valid = (qcnt_reg != 2'd0);
    assign push    = s_valid && s_ready;
    assign pop     = m_valid && m_ready;

    always_comb begin
        q_next[0] = pop ? q_reg[1] : q_reg[0];
        q_next[1] = pop ? q_reg[2] : q_reg[1];
        q_next[2] = q_reg[2];
        base      = qcnt_reg - {1'b0, pop};
        for (int j = 0; j < 3; j++) begin
            if (push && n_res != 2'd0 && base == 2'(j)) q_next[j] = res_first;
            if (push && n_res == 2'd2 && base + 2'd1 == 2'(j)) q_next[j] = res_second;
        end
        qcnt_next = base + (push ? n_res : 2'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= M_IDLE;
            lex_reg  <= '0;
            cnt_reg  <= '0;
            ovf_reg  <= 1'b0;
            line_reg <= 16'd1;
            qcnt_reg <= '0;
        end else begin
            if (push) begin
                mode_reg <= mode_next;
                lex_reg  <= lex_next;
                cnt_reg  <= cnt_next;
                ovf_reg  <= ovf_next;
                line_reg <= line_next;
            end
            qcnt_reg <= qcnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int j = 0; j < 3; j++) begin
            q_reg[j] <= q_next[j];
        end
    end

    assign m_token_kind    = q_reg[0].kind;
    assign m_lexeme        = q_reg[0].lex;
    assign m_lexeme_length = q_reg[0].len;
    assign m_line_number   = q_reg[0].line;
    assign m_error_code    = q_reg[0].err;
    assign m_last_of_run   = q_reg[0].last;

endmodule

/* rtl/scl_checker.sv */
`timescale 1ns / 1ps

`include "c_subset_lexical_scanner_unit_macros.svh"

module scl_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [5:0]  m_token_kind,
    input logic [55:0] m_lexeme,
    input logic [2:0]  m_lexeme_length,
    input logic [15:0] m_line_number,
    input logic [2:0]  m_error_code,
    input logic        m_last_of_run
);
    import scl_pkg::*;

    // a waiting word holds still
    `SCL_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable({m_token_kind, m_lexeme, m_lexeme_length, m_line_number, m_error_code, m_last_of_run}), "result word changed while stalled")

    // end tokens carry no lexeme
    `SCL_ASSERT_NOW(a_end_empty, aclk, aresetn, m_valid && m_token_kind == TK_END, m_lexeme_length == 3'd0 && m_lexeme == 56'd0, "end token with lexeme")

    // no error code on a good token; only error words and end words may carry one
    `SCL_ASSERT_NOW(a_err_code, aclk, aresetn, m_valid && m_token_kind != TK_ERROR && m_token_kind != TK_END, m_error_code == ERR_NONE, "error code on a good token")

    // line count starts at one and never wraps
    `SCL_ASSERT_NOW(a_line_nz, aclk, aresetn, m_valid, m_line_number != 16'd0, "line number zero")

endmodule

bind c_subset_lexical_scanner_unit scl_checker u_scl_checker (.*);
